/* rtl/spint_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the steered pose integrator.
package spint_pkg;

  // CORDIC datapath width, Q2.30 values with headroom
  localparam int CW = 34;
  // Quotient width of the modulo 2*pi reduction
  localparam int QW = 14;
  localparam int RECIP_SHIFT = 48;

  localparam logic [18:0] TWO_PI = 19'd411775;
  localparam logic [19:0] TWO_PI_W = 20'(TWO_PI);
  localparam logic [19:0] PI_W = 20'd205887;
  localparam logic [19:0] WRAP_HI = 20'(TWO_PI_W + PI_W);
  localparam logic signed [19:0] PI_S = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_S = 20'sd102944;
  // Floor reciprocal of 2*pi; quotient estimate is exact or one low
  localparam logic [29:0] RECIP = 30'((64'd1 << RECIP_SHIFT) / 64'(TWO_PI));
  // Multiple of 2*pi above 2^32 that makes every heading sum positive
  localparam logic [32:0] REDUCE_OFFSET = 33'(64'd10431 * 64'(TWO_PI));
  localparam logic [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_ANGLE_STEP    = 3'd0,
    REG_ANGLE_MINIMUM = 3'd1,
    REG_INDEX_LIMIT   = 3'd2,
    REG_FORWARD_SPEED = 3'd3,
    REG_TIME_STEP     = 3'd4
  } reg_index_t;

  localparam logic [15:0] RST_ANGLE_STEP = 16'd2294;
  localparam logic [17:0] RST_ANGLE_MINIMUM = 18'(-22938);
  localparam logic [5:0] RST_INDEX_LIMIT = 6'd20;
  localparam logic [31:0] RST_FORWARD_SPEED = 32'd65536;
  localparam logic [30:0] RST_TIME_STEP = 31'd655;

  typedef struct packed {
    logic [15:0] angle_step;
    logic [17:0] angle_minimum;
    logic [5:0]  index_limit;
    logic [31:0] forward_speed;
    logic [30:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic        err;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] heading;
    logic [23:0] change;
  } side_t;

  typedef struct packed {
    side_t         side;
    logic          neg;
    logic [CW-1:0] z;
  } ang_word_t;

  typedef struct packed {
    side_t         side;
    logic [CW-1:0] c;
    logic [CW-1:0] s;
  } trig_word_t;

  typedef struct packed {
    logic [31:0] next_x;
    logic [31:0] next_y;
    logic [31:0] next_heading;
    logic [31:0] rate_x;
    logic [31:0] rate_y;
    logic [31:0] heading_change;
    logic        index_error;
  } res_word_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic [31:0] r;
    if (!v[63] && (v[62:31] != 32'd0)) begin
      r = SAT_MAX;
    end else if (v[63] && (v[62:31] != 32'hffff_ffff)) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd843314857;
      5'd1:    r = 30'd497837829;
      5'd2:    r = 30'd263043837;
      5'd3:    r = 30'd133525159;
      5'd4:    r = 30'd67021687;
      5'd5:    r = 30'd33543516;
      5'd6:    r = 30'd16775851;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194283;
      5'd9:    r = 30'd2097149;
      5'd10:   r = 30'd1048576;
      5'd11:   r = 30'd524288;
      5'd12:   r = 30'd262144;
      5'd13:   r = 30'd131072;
      5'd14:   r = 30'd65536;
      5'd15:   r = 30'd32768;
      5'd16:   r = 30'd16384;
      5'd17:   r = 30'd8192;
      5'd18:   r = 30'd4096;
      5'd19:   r = 30'd2048;
      5'd20:   r = 30'd1024;
      5'd21:   r = 30'd512;
      5'd22:   r = 30'd256;
      5'd23:   r = 30'd128;
      5'd24:   r = 30'd64;
      5'd25:   r = 30'd32;
      5'd26:   r = 30'd16;
      5'd27:   r = 30'd8;
      5'd28:   r = 30'd4;
      5'd29:   r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/spint_angle.sv */
`timescale 1ns / 1ps
// Heading change, new heading and reduction of the angle into the CORDIC range.
module spint_angle (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  spint_pkg::cfg_t      cfg,
  input  logic                 in_valid,
  input  logic [31:0]          pose_x,
  input  logic [31:0]          pose_y,
  input  logic [31:0]          pose_heading,
  input  logic [5:0]           steer_index,
  output logic                 out_valid,
  output spint_pkg::ang_word_t out_word
);

  logic v1, v2, v3, v4, v5;
  spint_pkg::side_t s1, s2, s3, s4, s5;
  logic [31:0] ph1;
  logic [32:0] head2, hp2, hp3;
  logic [spint_pkg::QW-1:0] q3;
  logic [19:0] r0_4;
  logic [19:0] r2_5;

  logic [21:0] step_prod;
  logic [23:0] change_next;
  logic [32:0] head_next, hp_next;
  logic [62:0] q_prod;
  logic [31:0] heading_sat;
  logic [32:0] q_times;
  logic [32:0] rem_full;
  logic [19:0] r2_next;
  logic [19:0] r3;
  logic neg_next;
  logic [spint_pkg::CW-1:0] r3_ext;

  always_comb begin
    step_prod = cfg.angle_step * steer_index;
    change_next = {{6{cfg.angle_minimum[17]}}, cfg.angle_minimum} + {2'b00, step_prod};
    head_next = {ph1[31], ph1} + {{9{s1.change[23]}}, s1.change};
    hp_next = head_next + spint_pkg::REDUCE_OFFSET;
    q_prod = hp2 * spint_pkg::RECIP;
    heading_sat = (head2[32] ^ head2[31]) ?
                  (head2[32] ? spint_pkg::SAT_MIN : spint_pkg::SAT_MAX) : head2[31:0];
    q_times = q3 * spint_pkg::TWO_PI;
    rem_full = hp3 - q_times;
    // remainder is in [0, 4*pi); map it to (-pi, pi]
    if (r0_4 <= spint_pkg::PI_W) begin
      r2_next = r0_4;
    end else if (r0_4 <= spint_pkg::WRAP_HI) begin
      r2_next = r0_4 - spint_pkg::TWO_PI_W;
    end else begin
      r2_next = r0_4 - {spint_pkg::TWO_PI_W[18:0], 1'b0};
    end
    // fold into [-pi/2, pi/2]; neg flips both results
    if ($signed(r2_5) > spint_pkg::HALF_PI_S) begin
      r3 = r2_5 - spint_pkg::PI_W;
      neg_next = 1'b1;
    end else if ($signed(r2_5) < -spint_pkg::HALF_PI_S) begin
      r3 = r2_5 + spint_pkg::PI_W;
      neg_next = 1'b1;
    end else begin
      r3 = r2_5;
      neg_next = 1'b0;
    end
    r3_ext = spint_pkg::CW'($signed(r3));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.err <= steer_index > cfg.index_limit;
      s1.px <= pose_x;
      s1.py <= pose_y;
      s1.heading <= '0;
      s1.change <= change_next;
      ph1 <= pose_heading;

      s2 <= s1;
      head2 <= head_next;
      hp2 <= hp_next;

      s3 <= '{err: s2.err, px: s2.px, py: s2.py, heading: heading_sat, change: s2.change};
      hp3 <= hp2;
      q3 <= q_prod[spint_pkg::RECIP_SHIFT +: spint_pkg::QW];

      s4 <= s3;
      r0_4 <= rem_full[19:0];

      s5 <= s4;
      r2_5 <= r2_next;

      out_word.side <= s5;
      out_word.neg <= neg_next;
      out_word.z <= {r3_ext[spint_pkg::CW-15:0], 14'b0};
    end
  end

endmodule

/* rtl/spint_cordic.sv */
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one register stage per iteration.
module spint_cordic #(
  parameter int STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  spint_pkg::ang_word_t  in_word,
  output logic                  out_valid,
  output spint_pkg::trig_word_t out_word
);

  logic                     vld [STAGES+1];
  logic [spint_pkg::CW-1:0] xs  [STAGES+1];
  logic [spint_pkg::CW-1:0] ys  [STAGES+1];
  logic [spint_pkg::CW-1:0] zs  [STAGES+1];
  logic                     ng  [STAGES+1];
  spint_pkg::side_t         sd  [STAGES+1];

  assign vld[0] = in_valid;
  assign xs[0] = spint_pkg::CORDIC_GAIN;
  assign ys[0] = '0;
  assign zs[0] = in_word.z;
  assign ng[0] = in_word.neg;
  assign sd[0] = in_word.side;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [spint_pkg::CW-1:0] x_sh, y_sh, ang;
    assign x_sh = $signed(xs[k]) >>> k;
    assign y_sh = $signed(ys[k]) >>> k;
    assign ang = {{(spint_pkg::CW-30){1'b0}}, spint_pkg::atan_q30(5'(k))};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // rotate toward zero residual angle
        if (!zs[k][spint_pkg::CW-1]) begin
          xs[k+1] <= xs[k] - y_sh;
          ys[k+1] <= ys[k] + x_sh;
          zs[k+1] <= zs[k] - ang;
        end else begin
          xs[k+1] <= xs[k] + y_sh;
          ys[k+1] <= ys[k] - x_sh;
          zs[k+1] <= zs[k] + ang;
        end
        ng[k+1] <= ng[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_word.side = sd[STAGES];
  assign out_word.c = ng[STAGES] ? -xs[STAGES] : xs[STAGES];
  assign out_word.s = ng[STAGES] ? -ys[STAGES] : ys[STAGES];

endmodule

/* rtl/spint_motion.sv */
`timescale 1ns / 1ps
// Rates from speed and trig values, position update and final saturation.
module spint_motion (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  spint_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  input  spint_pkg::trig_word_t in_word,
  output logic                  out_valid,
  output spint_pkg::res_word_t  out_word
);

  logic v1, v2, v3, v4;
  spint_pkg::side_t s1, s2, s3, s4;
  logic signed [63:0] pc1, ps1;
  logic [31:0] rx2, ry2, rx3, ry3, rx4, ry4;
  logic signed [63:0] dpx3, dpy3;
  logic [47:0] dx4, dy4;

  logic signed [63:0] pc_next, ps_next, rc_rnd, rs_rnd, rc_sh, rs_sh;
  logic signed [63:0] dpx_next, dpy_next, dx_rnd, dy_rnd, dx_sh, dy_sh;
  logic [48:0] sum_x, sum_y;
  logic [31:0] nx, ny;

  always_comb begin
    pc_next = $signed(cfg.forward_speed) * $signed(in_word.c[31:0]);
    ps_next = $signed(cfg.forward_speed) * $signed(in_word.s[31:0]);
    rc_rnd = pc1 + 64'sd536870912;
    rs_rnd = ps1 + 64'sd536870912;
    rc_sh = rc_rnd >>> 30;
    rs_sh = rs_rnd >>> 30;
    dpx_next = $signed(rx2) * $signed({1'b0, cfg.time_step});
    dpy_next = $signed(ry2) * $signed({1'b0, cfg.time_step});
    dx_rnd = dpx3 + 64'sd32768;
    dy_rnd = dpy3 + 64'sd32768;
    dx_sh = dx_rnd >>> 16;
    dy_sh = dy_rnd >>> 16;
    sum_x = {s4.px[31], {16{s4.px[31]}}, s4.px} + {dx4[47], dx4};
    sum_y = {s4.py[31], {16{s4.py[31]}}, s4.py} + {dy4[47], dy4};
    nx = spint_pkg::sat32({{15{sum_x[48]}}, sum_x});
    ny = spint_pkg::sat32({{15{sum_y[48]}}, sum_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= in_word.side;
      pc1 <= pc_next;
      ps1 <= ps_next;

      s2 <= s1;
      rx2 <= spint_pkg::sat32(rc_sh);
      ry2 <= spint_pkg::sat32(rs_sh);

      s3 <= s2;
      rx3 <= rx2;
      ry3 <= ry2;
      dpx3 <= dpx_next;
      dpy3 <= dpy_next;

      s4 <= s3;
      rx4 <= rx3;
      ry4 <= ry3;
      dx4 <= dx_sh[47:0];
      dy4 <= dy_sh[47:0];

      // a rejected index gives all-zero result fields with index_error set
      if (s4.err) begin
        out_word <= '{next_x: '0, next_y: '0, next_heading: '0, rate_x: '0,
                      rate_y: '0, heading_change: '0, index_error: 1'b1};
      end else begin
        out_word <= '{next_x: nx, next_y: ny, next_heading: s4.heading,
                      rate_x: rx4, rate_y: ry4,
                      heading_change: {{8{s4.change[23]}}, s4.change},
                      index_error: 1'b0};
      end
    end
  end

endmodule

/* rtl/spint_outbuf.sv */
`timescale 1ns / 1ps
// Output register with a one-word skid stage; freezes the pipeline when full.
module spint_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  spint_pkg::res_word_t in_word,
  output logic                 in_ready,
  output logic                 out_valid,
  output spint_pkg::res_word_t out_word,
  input  logic                 out_ready
);

  logic skid_valid;
  spint_pkg::res_word_t skid_word;
  logic push;

  assign in_ready = !skid_valid;
  assign push = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_word <= skid_valid ? skid_word : in_word;
    end else if (push) begin
      // hold the word that arrived while the output was stalled
      skid_word <= in_word;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready && in_valid))
    else $error("skid stage filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid stage did not drain into output register");

endmodule

/* rtl/steered_pose_integrator.sv */
`timescale 1ns / 1ps
// Top level of the steered pose integrator: config registers and pipeline.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    pose_x, pose_y, pose_heading, steer_index
//   out      out_valid/out_ready  next_x, next_y, next_heading, rate_x, rate_y,
//                                 heading_change, index_error
//   cfg      cfg_write            cfg_index, cfg_data (no read-back)
//
// One word per cycle sustained while out_ready holds; the pipeline consists of the
// six angle-reduction stages, one stage per CORDIC iteration, five multiply and
// saturate stages and the output register.
// Reset clears all valid bits and loads the default register values.
// A stall holds every stage; the skid stage takes one more word while the
// output waits, then in_ready drops until it drains.
module steered_pose_integrator #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pose_x,
  input  logic [31:0] pose_y,
  input  logic [31:0] pose_heading,
  input  logic [5:0]  steer_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_x,
  output logic [31:0] next_y,
  output logic [31:0] next_heading,
  output logic [31:0] rate_x,
  output logic [31:0] rate_y,
  output logic [31:0] heading_change,
  output logic        index_error
);

  spint_pkg::cfg_t cfg;
  logic en;
  logic ang_valid, trig_valid, res_valid;
  spint_pkg::ang_word_t ang_word;
  spint_pkg::trig_word_t trig_word;
  spint_pkg::res_word_t res_word, out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_step <= spint_pkg::RST_ANGLE_STEP;
      cfg.angle_minimum <= spint_pkg::RST_ANGLE_MINIMUM;
      cfg.index_limit <= spint_pkg::RST_INDEX_LIMIT;
      cfg.forward_speed <= spint_pkg::RST_FORWARD_SPEED;
      cfg.time_step <= spint_pkg::RST_TIME_STEP;
    end else if (cfg_write) begin
      case (cfg_index)
        spint_pkg::REG_ANGLE_STEP:    cfg.angle_step <= cfg_data[15:0];
        spint_pkg::REG_ANGLE_MINIMUM: cfg.angle_minimum <= cfg_data[17:0];
        spint_pkg::REG_INDEX_LIMIT:   cfg.index_limit <= cfg_data[5:0];
        spint_pkg::REG_FORWARD_SPEED: cfg.forward_speed <= cfg_data;
        spint_pkg::REG_TIME_STEP:     cfg.time_step <= cfg_data[30:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  assign in_ready = en;

  spint_angle u_angle (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .pose_x       (pose_x),
    .pose_y       (pose_y),
    .pose_heading (pose_heading),
    .steer_index  (steer_index),
    .out_valid    (ang_valid),
    .out_word     (ang_word)
  );

  spint_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ang_valid),
    .in_word   (ang_word),
    .out_valid (trig_valid),
    .out_word  (trig_word)
  );

  spint_motion u_motion (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (trig_valid),
    .in_word   (trig_word),
    .out_valid (res_valid),
    .out_word  (res_word)
  );

  spint_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_word   (res_word),
    .in_ready  (en),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_ready (out_ready)
  );

  assign next_x = out_word.next_x;
  assign next_y = out_word.next_y;
  assign next_heading = out_word.next_heading;
  assign rate_x = out_word.rate_x;
  assign rate_y = out_word.rate_y;
  assign heading_change = out_word.heading_change;
  assign index_error = out_word.index_error;

endmodule
